>>> rtl/core/dual_encoder_pid_position_controller_assert.svh
// Assertion macros shared by the controller RTL.
`ifndef DUAL_ENCODER_PID_POSITION_CONTROLLER_ASSERT_SVH
`define DUAL_ENCODER_PID_POSITION_CONTROLLER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define DEPC_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define DEPC_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DEPC_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/depc_pkg.sv
// Shared types, constants and register codes of the dual encoder PID controller.
package depc_pkg;

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] REG_GAIN_P         = 2'd0;
    localparam logic [CFG_AW-1:0] REG_GAIN_I_DT      = 2'd1;
    localparam logic [CFG_AW-1:0] REG_GAIN_D_OVER_DT = 2'd2;
    localparam logic [CFG_AW-1:0] REG_TOLERANCE      = 2'd3;

    // operations
    localparam logic [1:0] OP_ENC  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_CLR  = 2'd2;

    // field and datapath widths
    localparam int GAIN_W = 16;
    localparam int TOL_W  = 8;
    localparam int PWR_W  = 8;
    localparam int FRAC_W = 8;
    localparam int POS_W  = 32;
    localparam int ERR_W  = POS_W + 1;
    localparam int DIF_W  = ERR_W + 1;
    localparam int SUM_W  = 48;
    localparam int SGN_W  = GAIN_W + 1;        // gain as a signed operand
    localparam int PE_W   = SGN_W + ERR_W;
    localparam int DD_W   = SGN_W + DIF_W;
    localparam int IT_W   = SGN_W + SUM_W;
    localparam int CTL_W  = IT_W + 1;

    localparam logic [GAIN_W-1:0] RST_GAIN_P         = 16'd256;
    localparam logic [GAIN_W-1:0] RST_GAIN_I_DT      = 16'd8;
    localparam logic [GAIN_W-1:0] RST_GAIN_D_OVER_DT = 16'd2560;
    localparam logic [TOL_W-1:0]  RST_TOLERANCE      = 8'd5;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [ERR_W-1:0] t_err;
    typedef logic signed [DIF_W-1:0] t_dif;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [SUM_W:0]   t_sum_x;
    typedef logic signed [SGN_W-1:0] t_gain_s;
    typedef logic signed [PE_W-1:0]  t_pe;
    typedef logic signed [DD_W-1:0]  t_dd;
    typedef logic signed [IT_W-1:0]  t_it;
    typedef logic signed [CTL_W-1:0] t_ctl;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i_dt;
        logic [GAIN_W-1:0] gain_d_over_dt;
        logic [TOL_W-1:0]  tolerance;
    } t_cfg;

    // one classified word between front and back
    typedef struct packed {
        logic pid;      // tick that runs the PID step
        logic at;       // tick with both channels arrived
        t_err e_one;
        t_err e_two;
        t_pos pos_one;
        t_pos pos_two;
    } t_qent;

    typedef struct packed {
        logic not_full;
        logic not_empty;
    } t_q_stat;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);
    localparam logic [Q_AW-1:0] Q_LAST     = Q_AW'(Q_DEPTH - 1);
    localparam logic [Q_CW-1:0] Q_CNT_FULL = Q_CW'(Q_DEPTH);

endpackage

>>> rtl/core/depc_if.sv
// Input and result channel interfaces of the dual encoder PID controller.
interface depc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic              channel;
    logic              pin_a;
    logic              pin_b;
    logic signed [31:0] target_one;
    logic signed [31:0] target_two;

    modport source (output valid, operation, channel, pin_a, pin_b, target_one, target_two,
                    input ready);
    modport sink   (input valid, operation, channel, pin_a, pin_b, target_one, target_two,
                    output ready);
endinterface

interface depc_out_if;
    logic              valid;
    logic              ready;
    logic [7:0]        power_one;
    logic              forward_one;
    logic [7:0]        power_two;
    logic              forward_two;
    logic              at_target;
    logic signed [31:0] position_one;
    logic signed [31:0] position_two;

    modport source (output valid, power_one, forward_one, power_two, forward_two, at_target,
                    position_one, position_two, input ready);
    modport sink   (input valid, power_one, forward_one, power_two, forward_two, at_target,
                    position_one, position_two, output ready);
endinterface

>>> rtl/core/depc_front.sv
// Front end: accepts words, keeps encoder counts, classifies ticks.
module depc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    depc_in_if.sink           i_in,
    input  depc_pkg::t_cfg    i_cfg,
    input  depc_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output depc_pkg::t_qent   o_entry
);

    depc_pkg::t_pos r_pos_one, r_pos_two, n_pos_one, n_pos_two;
    depc_pkg::t_err w_e_one, w_e_two;
    logic           w_accept, w_tick, w_arrived;
    depc_pkg::t_pos w_delta;

    function automatic logic near(input depc_pkg::t_err e,
                                  input logic [depc_pkg::TOL_W-1:0] tol);
        logic [depc_pkg::ERR_W-1:0] mag;
        logic [depc_pkg::ERR_W-1:0] lim;
        mag = e[depc_pkg::ERR_W-1] ? (~e + 1'b1) : e;
        lim = {{(depc_pkg::ERR_W - depc_pkg::TOL_W){1'b0}}, tol};
        return mag <= lim;
    endfunction

    assign i_in.ready = i_q_stat.not_full & i_rst_n;
    assign w_accept   = i_in.valid & i_in.ready;

    assign w_e_one   = depc_pkg::t_err'(i_in.target_one) - depc_pkg::t_err'(r_pos_one);
    assign w_e_two   = depc_pkg::t_err'(i_in.target_two) - depc_pkg::t_err'(r_pos_two);
    assign w_arrived = near(w_e_one, i_cfg.tolerance) & near(w_e_two, i_cfg.tolerance);
    assign w_tick    = (i_in.operation == depc_pkg::OP_TICK);
    // equal pins count up, differing pins count down
    assign w_delta   = (i_in.pin_a == i_in.pin_b) ? depc_pkg::t_pos'(1) : '1;

    always_comb begin
        n_pos_one = r_pos_one;
        n_pos_two = r_pos_two;
        case (i_in.operation)
            depc_pkg::OP_ENC: begin
                if (i_in.channel) begin
                    n_pos_two = r_pos_two + w_delta;
                end else begin
                    n_pos_one = r_pos_one + w_delta;
                end
            end
            depc_pkg::OP_CLR: begin
                n_pos_one = '0;
                n_pos_two = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_one <= '0;
            r_pos_two <= '0;
        end else if (w_accept) begin
            r_pos_one <= n_pos_one;
            r_pos_two <= n_pos_two;
        end
    end

    assign o_push          = w_accept;
    assign o_entry.pid     = w_tick & ~w_arrived;
    assign o_entry.at      = w_tick & w_arrived;
    assign o_entry.e_one   = w_e_one;
    assign o_entry.e_two   = w_e_two;
    assign o_entry.pos_one = n_pos_one;
    assign o_entry.pos_two = n_pos_two;

endmodule

>>> rtl/core/depc_fifo.sv
// Short word queue between front and back.
`include "dual_encoder_pid_position_controller_assert.svh"

module depc_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  depc_pkg::t_qent   i_wdata,
    input  logic              i_pop,
    output depc_pkg::t_qent   o_rdata,
    output depc_pkg::t_q_stat o_stat
);

    depc_pkg::t_qent             r_mem [depc_pkg::Q_DEPTH];
    logic [depc_pkg::Q_AW-1:0]   r_wp, r_rp;
    logic [depc_pkg::Q_CW-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == depc_pkg::Q_LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == depc_pkg::Q_LAST) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_rdata          = r_mem[r_rp];
    assign o_stat.not_full  = (r_cnt != depc_pkg::Q_CNT_FULL);
    assign o_stat.not_empty = (r_cnt != '0);

    `DEPC_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= depc_pkg::Q_CNT_FULL, "queue count beyond depth")
    `DEPC_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, r_cnt != depc_pkg::Q_CNT_FULL, "push into full queue")
    `DEPC_IMPLIES(a_no_underflow, i_clk, i_rst_n, i_pop, r_cnt != '0, "pop from empty queue")

endmodule

>>> rtl/core/depc_back.sv
// Back end: PID state update, gain multiplies, sum and drive saturation.
`include "dual_encoder_pid_position_controller_assert.svh"

module depc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  depc_pkg::t_cfg    i_cfg,
    input  depc_pkg::t_q_stat i_q_stat,
    input  depc_pkg::t_qent   i_head,
    output logic              o_pop,
    depc_out_if.source        o_out
);

    // PID state per channel
    depc_pkg::t_sum r_sum  [2];
    depc_pkg::t_err r_prev [2];

    // stage 1: saturated integrator, difference
    logic           r1_v, r1_pid, r1_at;
    depc_pkg::t_sum r1_s [2];
    depc_pkg::t_dif r1_d [2];
    depc_pkg::t_err r1_e [2];
    depc_pkg::t_pos r1_pos [2];
    depc_pkg::t_sum n1_s [2];
    depc_pkg::t_dif n1_d [2];
    depc_pkg::t_err w_he [2];
    depc_pkg::t_sum_x w_sx [2];

    // stage 2: products
    logic           r2_v, r2_pid, r2_at;
    depc_pkg::t_pe  r2_pe [2];
    depc_pkg::t_dd  r2_dd [2];
    depc_pkg::t_it  r2_it [2];
    depc_pkg::t_pos r2_pos [2];
    depc_pkg::t_gain_s w_gp, w_gi, w_gd;

    // stage 3: control signal
    logic           r3_v, r3_pid, r3_at;
    depc_pkg::t_ctl r3_c [2];
    depc_pkg::t_pos r3_pos [2];

    // stage 4: result register
    logic                      r4_v, r4_at;
    logic [depc_pkg::PWR_W-1:0] r4_pwr [2];
    logic                      r4_fwd [2];
    depc_pkg::t_pos            r4_pos [2];
    logic [depc_pkg::PWR_W:0]  n4_drv [2];

    logic w_en;

    function automatic logic [depc_pkg::PWR_W:0] drive(input depc_pkg::t_ctl c);
        logic [depc_pkg::CTL_W-1:0] mag;
        logic [depc_pkg::PWR_W-1:0] pwr;
        mag = c[depc_pkg::CTL_W-1] ? (~c + 1'b1) : c;
        if (|mag[depc_pkg::CTL_W-1:depc_pkg::FRAC_W+depc_pkg::PWR_W]) begin
            pwr = '1;
        end else begin
            pwr = mag[depc_pkg::FRAC_W+depc_pkg::PWR_W-1:depc_pkg::FRAC_W];
        end
        return {~c[depc_pkg::CTL_W-1], pwr};
    endfunction

    // whole pipe moves together, held while the result waits
    assign w_en  = ~r4_v | o_out.ready;
    assign o_pop = w_en & i_q_stat.not_empty;

    assign w_he[0] = i_head.e_one;
    assign w_he[1] = i_head.e_two;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_sx[k] = depc_pkg::t_sum_x'(r_sum[k]) + depc_pkg::t_sum_x'(w_he[k]);
            if (w_sx[k][depc_pkg::SUM_W] != w_sx[k][depc_pkg::SUM_W-1]) begin
                n1_s[k] = w_sx[k][depc_pkg::SUM_W] ? {1'b1, {(depc_pkg::SUM_W-1){1'b0}}}
                                                    : {1'b0, {(depc_pkg::SUM_W-1){1'b1}}};
            end else begin
                n1_s[k] = w_sx[k][depc_pkg::SUM_W-1:0];
            end
            n1_d[k] = depc_pkg::t_dif'(w_he[k]) - depc_pkg::t_dif'(r_prev[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_sum[k]  <= '0;
                r_prev[k] <= '0;
            end
        end else if (o_pop && i_head.pid) begin
            for (int k = 0; k < 2; k++) begin
                r_sum[k]  <= n1_s[k];
                r_prev[k] <= w_he[k];
            end
        end
    end

    assign w_gp = depc_pkg::t_gain_s'({1'b0, i_cfg.gain_p});
    assign w_gi = depc_pkg::t_gain_s'({1'b0, i_cfg.gain_i_dt});
    assign w_gd = depc_pkg::t_gain_s'({1'b0, i_cfg.gain_d_over_dt});

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n4_drv[k] = drive(r3_c[k]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= o_pop;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_pid    <= i_head.pid;
            r1_at     <= i_head.at;
            r1_pos[0] <= i_head.pos_one;
            r1_pos[1] <= i_head.pos_two;
            r2_pid    <= r1_pid;
            r2_at     <= r1_at;
            r3_pid    <= r2_pid;
            r3_at     <= r2_at;
            r4_at     <= r3_at;
            for (int k = 0; k < 2; k++) begin
                r1_s[k]   <= n1_s[k];
                r1_d[k]   <= n1_d[k];
                r1_e[k]   <= w_he[k];
                r2_pe[k]  <= depc_pkg::t_pe'(w_gp) * depc_pkg::t_pe'(r1_e[k]);
                r2_dd[k]  <= depc_pkg::t_dd'(w_gd) * depc_pkg::t_dd'(r1_d[k]);
                r2_it[k]  <= depc_pkg::t_it'(w_gi) * depc_pkg::t_it'(r1_s[k]);
                r2_pos[k] <= r1_pos[k];
                r3_c[k]   <= depc_pkg::t_ctl'(r2_it[k]) + depc_pkg::t_ctl'(r2_pe[k])
                             + depc_pkg::t_ctl'(r2_dd[k]);
                r3_pos[k] <= r2_pos[k];
                r4_pwr[k] <= r3_pid ? n4_drv[k][depc_pkg::PWR_W-1:0] : '0;
                r4_fwd[k] <= r3_pid ? n4_drv[k][depc_pkg::PWR_W] : 1'b1;
                r4_pos[k] <= r3_pos[k];
            end
        end
    end

    assign o_out.valid        = r4_v;
    assign o_out.power_one    = r4_pwr[0];
    assign o_out.forward_one  = r4_fwd[0];
    assign o_out.power_two    = r4_pwr[1];
    assign o_out.forward_two  = r4_fwd[1];
    assign o_out.at_target    = r4_at;
    assign o_out.position_one = r4_pos[0];
    assign o_out.position_two = r4_pos[1];

    `DEPC_IMPLIES(a_flags_excl, i_clk, i_rst_n, r1_v, !(r1_pid && r1_at), "tick both arrived and running PID")
    `DEPC_IMPLIES(a_at_idle, i_clk, i_rst_n, r4_v && r4_at, r4_pwr[0] == '0 && r4_pwr[1] == '0 && r4_fwd[0] && r4_fwd[1], "arrived word with drive")
    `DEPC_NEXT(a_stall_hold, i_clk, i_rst_n, r4_v && !o_out.ready, $stable(r3_v) && r4_v && $stable(r4_pos[0]) && $stable(r4_pos[1]), "pipe moved while result stalled")

endmodule

>>> rtl/core/dual_encoder_pid_position_controller.sv
// A word accepted into the queue then passes through 4 back stages before its result shows.
// Throughput: one word per cycle; the pipe only holds while the result word is not taken.
// The front takes words while the 4-entry queue has room, independent of the back.
// Reset (synchronous, active low): encoder counts, PID state and the queue clear at once,
// gains and tolerance return to their defaults; no clearing pass, ready rises after reset.
module dual_encoder_pid_position_controller (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    depc_in_if.sink                      i_in,
    depc_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [depc_pkg::CFG_AW-1:0]  i_cfg_idx,
    input  logic [depc_pkg::CFG_DW-1:0]  i_cfg_data
);

    // Configuration registers, to be written by the user only while idle (not
    // enforced by the block), so the front (tolerance) and back (gains) read them directly.
    depc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= depc_pkg::RST_GAIN_P;
            r_cfg.gain_i_dt      <= depc_pkg::RST_GAIN_I_DT;
            r_cfg.gain_d_over_dt <= depc_pkg::RST_GAIN_D_OVER_DT;
            r_cfg.tolerance      <= depc_pkg::RST_TOLERANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                depc_pkg::REG_GAIN_P:         r_cfg.gain_p <= i_cfg_data;
                depc_pkg::REG_GAIN_I_DT:      r_cfg.gain_i_dt <= i_cfg_data;
                depc_pkg::REG_GAIN_D_OVER_DT: r_cfg.gain_d_over_dt <= i_cfg_data;
                depc_pkg::REG_TOLERANCE:
                    r_cfg.tolerance <= i_cfg_data[depc_pkg::TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front -> queue -> back. The front owns the encoder counts and computes
    // both errors and the arrival test; every word carries the counts as they
    // stand after it, so the back never looks at front state.
    logic              w_push, w_pop;
    depc_pkg::t_qent   w_wdata, w_rdata;
    depc_pkg::t_q_stat w_q_stat;

    depc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_entry  (w_wdata)
    );

    depc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wdata),
        .i_pop   (w_pop),
        .o_rdata (w_rdata),
        .o_stat  (w_q_stat)
    );

    // Back: integrator/difference update on popping a PID tick, then gain products,
    // sum, and magnitude saturation into the result register (zero drive for other words).
    depc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_stat (w_q_stat),
        .i_head   (w_rdata),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

endmodule
